FILE: sv/itdt_pkg.sv
package itdt_pkg;

    // Decimal digit cells; 2^64 needs twenty decimal digits.
    localparam int unsigned DIGIT_SLOTS = 20;
    localparam int unsigned DCNT_W      = $clog2(DIGIT_SLOTS + 1);

    // Width and minimum digit count saturate here.
    localparam logic [5:0] FIELD_LIMIT = 6'd63;

    // One double-dabble step per magnitude bit.
    localparam int unsigned NUM_W = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

endpackage

FILE: sv/itdt_ifs.sv
interface itdt_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] number;
    logic        [5:0]  field_width;
    logic signed [6:0]  min_digits;
    logic               force_plus;
    logic               zero_pad;

    modport source (
        output valid, number, field_width, min_digits, force_plus, zero_pad,
        input  ready
    );
    modport sink (
        input  valid, number, field_width, min_digits, force_plus, zero_pad,
        output ready
    );
endinterface

interface itdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (
        output valid, char_byte, last_char,
        input  ready
    );
    modport sink (
        input  valid, char_byte, last_char,
        output ready
    );
endinterface

FILE: sv/integer_to_decimal_text_unit.sv
// Signed decimal text unit: formats one signed 64-bit number as printf-style
// %d text, one ASCII character per output transaction.
// i_in carries the number with its field width, minimum digit count, force-plus
// and zero-pad controls; o_out carries one character and a last mark that is
// set on the final digit of each number.
// The magnitude is converted in a row of twenty BCD digit cells, one bit per
// cycle. The row then shifts out leading zero digits, and the setup state sets
// up the pad counts. Within each phase characters leave at one per cycle while
// the receiver takes them (at most 64 characters per number), and one item is
// in work at a time; i_in.ready is high only while the unit is idle.
// The output register may still hold the last character of a number while the
// next number is accepted. When the receiver stalls, the character and its
// last mark hold and the unit waits. Reset empties the output register and
// returns the unit to idle.
module integer_to_decimal_text_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itdt_in_if.sink     i_in,
    itdt_out_if.source  o_out
);
    import itdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_SETUP,
        S_SPACE,
        S_SIGN,
        S_ZERO,
        S_DIGIT
    } t_state;

    t_state              r_state;
    logic [NUM_W-1:0]    r_mag;
    logic [5:0]          r_step;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [5:0]          r_width;
    logic [5:0]          r_min;
    logic                r_neg;
    logic                r_sign;
    logic                r_zero;
    logic [5:0]          r_spaces;
    logic [5:0]          r_zeros;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    t_cell_op            w_op;
    logic [DIGIT_SLOTS-1:0] w_obit;
    logic [3:0]          w_dig [DIGIT_SLOTS];
    logic [3:0]          w_top;
    logic                w_accept;
    logic                w_adv;
    logic                w_emit;
    logic                w_norm_shift;
    logic [NUM_W-1:0]    w_mag_in;
    logic [5:0]          w_width_in;
    logic [5:0]          w_min_in;
    logic [6:0]          w_width7;
    logic [6:0]          w_ws;
    logic [5:0]          w_min_eff;
    logic [5:0]          w_dcnt6;
    logic [5:0]          w_maxcd;
    logic [6:0]          w_body;
    logic [6:0]          w_sp_diff;
    logic [5:0]          w_spaces;
    logic [5:0]          w_zeros;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_byte = r_out_char;
    assign o_out.last_char = r_out_last;

    assign w_accept = i_in.valid && (r_state == S_IDLE);
    assign w_adv    = !r_out_valid || o_out.ready;
    assign w_top    = w_dig[DIGIT_SLOTS-1];
    assign w_norm_shift = (r_dcnt > DCNT_W'(1)) && (w_top == 4'd0);

    // A character is loaded into the output register in this cycle.
    assign w_emit = w_adv && (((r_state == S_SPACE) && (r_spaces != 6'd0)) ||
                              ((r_state == S_SIGN) && r_sign) ||
                              ((r_state == S_ZERO) && (r_zeros != 6'd0)) ||
                              (r_state == S_DIGIT));

    assign w_mag_in   = i_in.number[NUM_W-1] ? (~i_in.number + 64'd1) : i_in.number;
    assign w_width_in = (i_in.field_width > FIELD_LIMIT) ? FIELD_LIMIT : i_in.field_width;
    assign w_min_in   = i_in.min_digits[6] ? 6'd0 :
                        ((i_in.min_digits[5:0] > FIELD_LIMIT) ? FIELD_LIMIT
                                                              : i_in.min_digits[5:0]);

    // Pad arithmetic, used in the setup cycle once the digit count is known.
    always_comb begin
        w_width7  = {1'b0, r_width};
        w_ws      = w_width7 - {6'd0, r_sign};
        w_min_eff = (r_zero && (w_width7 > {6'd0, r_sign}) && ({1'b0, r_min} < w_ws))
                    ? w_ws[5:0] : r_min;
        w_dcnt6   = 6'(r_dcnt);
        w_maxcd   = (w_dcnt6 > w_min_eff) ? w_dcnt6 : w_min_eff;
        w_body    = {1'b0, w_maxcd} + {6'd0, r_sign};
        w_sp_diff = w_width7 - w_body;
        w_spaces  = (!r_zero && (w_width7 > w_body)) ? w_sp_diff[5:0] : 6'd0;
        w_zeros   = (w_min_eff > w_dcnt6) ? (w_min_eff - w_dcnt6) : 6'd0;
    end

    always_comb begin
        w_op = OP_HOLD;
        case (r_state)
            S_IDLE:  if (w_accept) w_op = OP_CLEAR;
            S_CONV:  w_op = OP_DABBLE;
            S_NORM:  if (w_norm_shift) w_op = OP_SHIFT;
            S_DIGIT: if (w_adv) w_op = OP_SHIFT;
            default: w_op = OP_HOLD;
        endcase
    end

    // Cell 0 takes the next magnitude bit; each cell hands its carry and its
    // digit to the cell above.
    for (genvar k = 0; k < DIGIT_SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            itdt_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_bit   (r_mag[NUM_W-1]),
                .i_digit (4'd0),
                .o_bit   (w_obit[k]),
                .o_digit (w_dig[k])
            );
        end else begin : g_next
            itdt_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_bit   (w_obit[k-1]),
                .i_digit (w_dig[k-1]),
                .o_bit   (w_obit[k]),
                .o_digit (w_dig[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag   <= w_mag_in;
                        r_width <= w_width_in;
                        r_min   <= w_min_in;
                        r_neg   <= i_in.number[NUM_W-1];
                        r_sign  <= i_in.number[NUM_W-1] || i_in.force_plus;
                        r_zero  <= i_in.zero_pad;
                        r_step  <= 6'(NUM_W - 1);
                        r_dcnt  <= DCNT_W'(DIGIT_SLOTS);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[NUM_W-2:0], 1'b0};
                    if (r_step == 6'd0) begin
                        r_state <= S_NORM;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_NORM: begin
                    if (w_norm_shift) begin
                        r_dcnt <= r_dcnt - DCNT_W'(1);
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_spaces <= w_spaces;
                    r_zeros  <= w_zeros;
                    r_state  <= S_SPACE;
                end
                S_SPACE: begin
                    if (r_spaces == 6'd0) begin
                        r_state <= S_SIGN;
                    end else if (w_adv) begin
                        r_out_char  <= CHAR_SPACE;
                        r_out_last  <= 1'b0;
                        r_spaces    <= r_spaces - 6'd1;
                    end
                end
                S_SIGN: begin
                    if (!r_sign) begin
                        r_state <= S_ZERO;
                    end else if (w_adv) begin
                        r_out_char  <= r_neg ? CHAR_MINUS : CHAR_PLUS;
                        r_out_last  <= 1'b0;
                        r_state     <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (r_zeros == 6'd0) begin
                        r_state <= S_DIGIT;
                    end else if (w_adv) begin
                        r_out_char  <= CHAR_ZERO;
                        r_out_last  <= 1'b0;
                        r_zeros     <= r_zeros - 6'd1;
                    end
                end
                S_DIGIT: begin
                    if (w_adv) begin
                        r_out_char  <= CHAR_ZERO | {4'd0, w_top};
                        r_out_last  <= (r_dcnt == DCNT_W'(1));
                        if (r_dcnt == DCNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_dcnt <= r_dcnt - DCNT_W'(1);
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: sv/itdt_cell.sv
module itdt_cell (
    input  logic               i_clk,
    input  itdt_pkg::t_cell_op i_op,
    input  logic               i_bit,
    input  logic [3:0]         i_digit,
    output logic               o_bit,
    output logic [3:0]         o_digit
);
    import itdt_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three before the shift so the digit carries correctly into its neighbor.
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_op)
            OP_HOLD:   n_digit = r_digit;
            OP_CLEAR:  n_digit = 4'd0;
            OP_DABBLE: n_digit = {w_adj[2:0], i_bit};
            OP_SHIFT:  n_digit = i_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: sv/itdt_checker.sv
module itdt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);
    import itdt_pkg::*;

    // A character waiting on a stalled receiver must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output transaction changed while stalled");

    // Only spaces, signs and digits are ever produced.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == CHAR_SPACE) || (i_out_char == CHAR_MINUS) ||
                        (i_out_char == CHAR_PLUS) ||
                        ((i_out_char >= CHAR_ZERO) && (i_out_char <= 8'h39)))
        else $error("output character outside the decimal text set");

    // One number is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a number was in work");

    // When idle, anything left in the output register ends a number.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid || i_out_last)
        else $error("idle with an unfinished number in the output register");

endmodule

bind integer_to_decimal_text_unit itdt_checker u_itdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_byte),
    .i_out_last  (o_out.last_char)
);

FILE: tb/itdt_checker.sv
`timescale 1ns / 1ps

module itdt_tb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    itdt_in_if   number_ch,
    itdt_out_if  text_ch,
    output int   o_mismatch_count,
    output int   o_pending_chars,
    output int   o_numbers_seen,
    output int   o_chars_seen
);
    import itdt_pkg::*;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } t_text_char;

    t_text_char expected_text[$];

    int mismatches    = 0;
    int pending       = 0;
    int numbers_taken = 0;
    int chars_taken   = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending_chars  = pending;
    assign o_numbers_seen   = numbers_taken;
    assign o_chars_seen     = chars_taken;

    function automatic void queue_char(input logic [7:0] ch);
        t_text_char item;
        item.char_byte = ch;
        item.last_char = 1'b0;
        expected_text.push_back(item);
    endfunction

    // Builds the printf-style %d text for one number and queues its characters.
    function automatic void format_decimal(
        input logic [63:0] num,
        input logic [5:0]  fw,
        input logic [6:0]  md,
        input logic        plus,
        input logic        zpad
    );
        logic [7:0]  digits [DIGIT_SLOTS];
        logic [63:0] mag;
        logic        neg;
        int unsigned width;
        int unsigned minimum;
        int unsigned sign_len;
        int unsigned count;
        int unsigned body;
        t_text_char  tail;

        neg   = num[63];
        mag   = neg ? (~num + 64'd1) : num;
        width = fw;
        if (width > FIELD_LIMIT) begin
            width = FIELD_LIMIT;
        end
        // Any negative minimum means that none was given.
        minimum = md[6] ? 0 : md;
        if (minimum > FIELD_LIMIT) begin
            minimum = FIELD_LIMIT;
        end

        count = 0;
        do begin
            if (count < DIGIT_SLOTS) begin
                digits[count] = CHAR_ZERO + 8'(mag % 64'd10);
                count++;
            end
            mag = mag / 64'd10;
        end while (mag != 64'd0);

        sign_len = (neg || plus) ? 1 : 0;
        if (zpad && width > sign_len && minimum < width - sign_len) begin
            minimum = width - sign_len;
        end
        body = sign_len + ((count > minimum) ? count : minimum);

        if (!zpad) begin
            while (width > body) begin
                queue_char(CHAR_SPACE);
                width--;
            end
        end
        if (neg) begin
            queue_char(CHAR_MINUS);
        end else if (plus) begin
            queue_char(CHAR_PLUS);
        end
        while (minimum > count) begin
            queue_char(CHAR_ZERO);
            minimum--;
        end
        while (count != 0) begin
            count--;
            queue_char(digits[count]);
        end

        tail = expected_text.pop_back();
        tail.last_char = 1'b1;
        expected_text.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (number_ch.valid && number_ch.ready) begin
                format_decimal(number_ch.number, number_ch.field_width,
                               number_ch.min_digits, number_ch.force_plus,
                               number_ch.zero_pad);
                numbers_taken++;
            end
            if (text_ch.valid && text_ch.ready) begin
                chars_taken++;
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: character %h (last %b) arrived with none expected",
                                 $realtime, text_ch.char_byte, text_ch.last_char);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (text_ch.char_byte !== want.char_byte ||
                        text_ch.last_char !== want.last_char) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: char_byte expected %h got %h,",
                                      " last_char expected %b got %b"},
                                     $realtime, want.char_byte, text_ch.char_byte,
                                     want.last_char, text_ch.last_char);
                        end
                    end
                end
            end
            pending = expected_text.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import itdt_pkg::*;

    // Minimum digit codes: all ones is -1, and the top bit alone is -64.
    localparam logic [6:0]  NO_MIN_DIGITS  = 7'h7F;
    localparam logic [6:0]  MOST_NEG_DIGITS = 7'h40;
    localparam logic [63:0] MOST_NEGATIVE  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POSITIVE  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_NUMBERS = 100;
    localparam int          STEADY_TAIL    = 20;

    logic i_clk;
    logic i_rst_n;
    bit   steady_traffic = 1'b0;
    int   directed_count = 0;
    int   mismatch_count;
    int   pending_chars;
    int   numbers_seen;
    int   chars_seen;

    itdt_in_if  number_ch ();
    itdt_out_if text_ch ();

    integer_to_decimal_text_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (number_ch),
        .o_out   (text_ch)
    );

    itdt_tb_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .number_ch        (number_ch),
        .text_ch          (text_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending_chars  (pending_chars),
        .o_numbers_seen   (numbers_seen),
        .o_chars_seen     (chars_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : sink_pacing
        int burst;
        text_ch.ready = 1'b0;
        forever begin
            if (steady_traffic || $urandom_range(0, 2) != 0) begin
                text_ch.ready <= 1'b1;
                burst = $urandom_range(1, 40);
            end else begin
                text_ch.ready <= 1'b0;
                burst = $urandom_range(1, 10);
            end
            repeat (burst) @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_number(
        input logic [63:0] num,
        input logic [5:0]  fw,
        input logic [6:0]  md,
        input logic        plus,
        input logic        zpad
    );
        int gap;
        if (!steady_traffic && $urandom_range(0, 3) == 0) begin
            number_ch.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
        number_ch.valid       <= 1'b1;
        number_ch.number      <= num;
        number_ch.field_width <= fw;
        number_ch.min_digits  <= md;
        number_ch.force_plus  <= plus;
        number_ch.zero_pad    <= zpad;
        @(posedge i_clk);
        while (!number_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_directed(
        input logic [63:0] num,
        input logic [5:0]  fw,
        input logic [6:0]  md,
        input logic        plus,
        input logic        zpad
    );
        send_number(num, fw, md, plus, zpad);
        directed_count++;
    endtask

    initial begin : stimulus
        logic [63:0] num;
        logic [5:0]  fw;
        logic [6:0]  md;

        i_rst_n               = 1'b0;
        number_ch.valid       = 1'b0;
        number_ch.number      = '0;
        number_ch.field_width = '0;
        number_ch.min_digits  = '0;
        number_ch.force_plus  = 1'b0;
        number_ch.zero_pad    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_directed(64'd0, 6'd0, NO_MIN_DIGITS, 1'b0, 1'b0);
        send_directed(64'd0, 6'd0, 7'd0, 1'b0, 1'b0);
        send_directed(64'd0, 6'd0, 7'd0, 1'b1, 1'b0);
        send_directed(MOST_NEGATIVE, 6'd0, NO_MIN_DIGITS, 1'b0, 1'b0);
        send_directed(MOST_POSITIVE, 6'd0, NO_MIN_DIGITS, 1'b1, 1'b0);
        send_directed(-64'sd1, 6'd63, NO_MIN_DIGITS, 1'b0, 1'b1);
        send_directed(64'd42, 6'd63, NO_MIN_DIGITS, 1'b0, 1'b0);
        send_directed(64'd7, 6'd0, 7'd63, 1'b1, 1'b0);
        send_directed(64'd123, 6'd8, MOST_NEG_DIGITS, 1'b0, 1'b0);
        send_directed(64'd123, 6'd8, NO_MIN_DIGITS, 1'b0, 1'b1);
        send_directed(-64'sd5, 6'd1, NO_MIN_DIGITS, 1'b0, 1'b1);
        send_directed(64'd5, 6'd1, NO_MIN_DIGITS, 1'b1, 1'b1);
        send_directed(64'd12345, 6'd10, 7'd7, 1'b0, 1'b0);
        send_directed(-64'sd12345, 6'd10, 7'd3, 1'b0, 1'b1);
        send_directed(64'd999, 6'd2, 7'd2, 1'b0, 1'b0);
        send_directed(MOST_NEGATIVE, 6'd63, 7'd63, 1'b1, 1'b1);
        send_directed(64'd1_000_000_000_000_000_000, 6'd25, NO_MIN_DIGITS, 1'b1, 1'b0);
        send_directed(-64'sd1_000_000_000_000_000_000, 6'd0, 7'd21, 1'b0, 1'b0);
        send_directed(64'd0, 6'd5, NO_MIN_DIGITS, 1'b0, 1'b1);
        send_directed(64'd0, 6'd63, 7'd0, 1'b0, 1'b0);
        send_directed(-64'sd9, 6'd3, 7'd2, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n == RANDOM_NUMBERS - STEADY_TAIL) begin
                steady_traffic = 1'b1;
            end
            // A random shift spreads the magnitudes over every digit count.
            num = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) begin
                num = ~num + 64'd1;
            end
            if ($urandom_range(0, 15) == 0) begin
                num = {$urandom, $urandom};
            end
            fw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 24));
            case ($urandom_range(0, 2))
                0: md = 7'($urandom);
                1: md = 7'(-$urandom_range(1, 64));
                default: md = 7'($urandom_range(0, 24));
            endcase
            send_number(num, fw, md, 1'($urandom), 1'($urandom));
        end
        number_ch.valid <= 1'b0;

        while (pending_chars != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Converted %0d numbers (%0d directed, the rest random) into %0d characters,",
                 numbers_seen, directed_count, chars_seen);
        $display("covering both 64-bit extremes, full widths, space and zero fill, and forced signs.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d character transactions differed from the prediction.",
                     mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Run timed out with %0d characters still awaited.", pending_chars);
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
sv/itdt_pkg.sv
sv/itdt_ifs.sv
sv/itdt_cell.sv
sv/integer_to_decimal_text_unit.sv
sv/itdt_checker.sv
tb/itdt_checker.sv
tb/tb.sv
